// ===== rtl/pidis_pkg.sv =====
// Shared types, register indexes and 64-bit saturating helpers for the PID block.
// Used by pidis_mul, pidis_div and pid_with_integral_separation; depends on nothing.
package pidis_pkg;

  // Width of the internal saturating arithmetic and of one partial-product half.
  localparam int ACC_W  = 64;
  localparam int HALF_W = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_UPPER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOWER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_UPPER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LOWER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_RANGE      = 3'd7;

  typedef logic signed [ACC_W-1:0] s64_t;
  typedef logic        [ACC_W-1:0] u64_t;

  localparam s64_t S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam s64_t S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Saturate a 65-bit signed value to the 64-bit range.
  function automatic s64_t sat65(input logic signed [ACC_W:0] x);
    s64_t r;
    if (x[ACC_W] != x[ACC_W-1]) begin
      r = x[ACC_W] ? S64_MIN : S64_MAX;
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic s64_t sat_add(input s64_t a, input s64_t b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    return sat65(s);
  endfunction

  // Crossed limits resolve to the lower limit.
  function automatic s64_t clamp(input s64_t x, input s64_t lo, input s64_t hi);
    s64_t r;
    r = x;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  // Apply a sign to a magnitude; big means the magnitude reached 2^63 or more.
  function automatic s64_t from_mag(input logic neg, input logic big, input u64_t q);
    s64_t r;
    if (big) begin
      r = neg ? S64_MIN : S64_MAX;
    end else begin
      r = s64_t'(q);
      if (neg) r = -r;
    end
    return r;
  endfunction

endpackage

// ===== rtl/pidis_mul.sv =====
// Iterative fixed-point multiplier: 64x64 magnitude product from four 32x32 partial products,
// floored shift by FRAC_BITS and saturation to 64 bits. Depends on pidis_pkg.
module pidis_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pidis_pkg::s64_t     a_i,
  input  pidis_pkg::s64_t     b_i,
  output logic                done_o,
  output pidis_pkg::s64_t     res_o
);

  localparam int AW = pidis_pkg::ACC_W;
  localparam int HW = pidis_pkg::HALF_W;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_PROD = 3'd1;
  localparam logic [2:0] M_LAST = 3'd2;
  localparam logic [2:0] M_RND  = 3'd3;
  localparam logic [2:0] M_SGN  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                done_q, done_d;

  logic                neg_q;
  pidis_pkg::u64_t     ma_q, mb_q;
  logic [AW-1:0]       pp_q;
  logic [1:0]          ppk_q;
  logic [2*AW-1:0]     acc_q;
  pidis_pkg::u64_t     q_q;
  logic                big_q;
  pidis_pkg::s64_t     res_q;

  logic [HW-1:0]       a_half, b_half;
  logic [2*AW-1:0]     pp_shifted;
  logic [AW:0]         q_round;
  logic                rem_nz, hi_nz;

  assign a_half = cnt_q[0] ? ma_q[AW-1:HW] : ma_q[HW-1:0];
  assign b_half = cnt_q[1] ? mb_q[AW-1:HW] : mb_q[HW-1:0];

  always_comb begin
    unique case (ppk_q)
      2'd1:    pp_shifted = {{HW{1'b0}}, pp_q, {HW{1'b0}}};
      2'd2:    pp_shifted = {pp_q, {AW{1'b0}}};
      default: pp_shifted = {{AW{1'b0}}, pp_q};
    endcase
  end

  assign rem_nz  = |acc_q[FRAC_BITS-1:0];
  assign hi_nz   = |acc_q[2*AW-1:AW+FRAC_BITS];
  assign q_round = {1'b0, acc_q[AW+FRAC_BITS-1:FRAC_BITS]} + (AW+1)'(neg_q && rem_nz);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      M_IDLE: begin
        if (start_i) begin
          cnt_d   = 2'd0;
          state_d = M_PROD;
        end
      end
      M_PROD: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = M_LAST;
      end
      M_LAST: state_d = M_RND;
      M_RND:  state_d = M_SGN;
      M_SGN: begin
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      neg_q <= a_i[AW-1] ^ b_i[AW-1];
      ma_q  <= a_i[AW-1] ? -a_i : a_i;
      mb_q  <= b_i[AW-1] ? -b_i : b_i;
      acc_q <= '0;
    end
    if (state_q == M_PROD) begin
      pp_q  <= a_half * b_half;
      ppk_q <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
      if (cnt_q != 2'd0) acc_q <= acc_q + pp_shifted;
    end
    if (state_q == M_LAST) acc_q <= acc_q + pp_shifted;
    if (state_q == M_RND) begin
      q_q   <= q_round[AW-1:0];
      big_q <= hi_nz | q_round[AW] | q_round[AW-1];
    end
    if (state_q == M_SGN) res_q <= pidis_pkg::from_mag(neg_q, big_q, q_q);
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/pidis_div.sv =====
// Restoring divider for the derivative quotient (d << FRAC_BITS) / t, one quotient bit per
// cycle, truncated toward zero and saturated to 64 bits. Depends on pidis_pkg.
module pidis_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pidis_pkg::s64_t       d_i,
  input  logic [DATA_WIDTH-2:0] t_i,
  output logic                  done_o,
  output pidis_pkg::s64_t       res_o
);

  localparam int AW    = pidis_pkg::ACC_W;
  // The difference has at most DATA_WIDTH+1 bits, so the shifted numerator fits in NUM_W.
  localparam int NUM_W = (DATA_WIDTH + 1 + FRAC_BITS > AW) ? AW : DATA_WIDTH + 1 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_SGN  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;

  logic                  neg_q, ovf_q;
  logic [NUM_W-1:0]      num_q, quo_q;
  logic [DATA_WIDTH-2:0] den_q, rem_q;
  pidis_pkg::s64_t       res_q;

  pidis_pkg::u64_t       ud, num_full;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic                  ge;

  assign ud       = d_i[AW-1] ? -d_i : d_i;
  assign num_full = ud << FRAC_BITS;
  assign rem_sh   = {rem_q, num_q[NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          cnt_d   = CNT_W'(NUM_W);
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) state_d = D_SGN;
      end
      D_SGN: begin
        done_d  = 1'b1;
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      neg_q <= d_i[AW-1];
      ovf_q <= |ud[AW-1 -: FRAC_BITS];
      num_q <= num_full[NUM_W-1:0];
      den_q <= t_i;
      rem_q <= '0;
      quo_q <= '0;
    end
    if (state_q == D_RUN) begin
      rem_q <= ge ? (DATA_WIDTH-1)'(rem_sh - {1'b0, den_q}) : rem_sh[DATA_WIDTH-2:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
      num_q <= num_q << 1;
    end
    if (state_q == D_SGN) begin
      res_q <= pidis_pkg::from_mag(neg_q, ovf_q | AW'(quo_q) >= {1'b1, {(AW-1){1'b0}}},
                                   AW'(quo_q));
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/pid_with_integral_separation.sv =====
// PID controller with integral separation: top level with sequencer and configuration registers.
// Instantiates pidis_mul and pidis_div; depends on pidis_pkg.
//
// Each input word carries a signed error sample and an unsigned step time, both in fixed
// point with FRAC_BITS fraction bits, and a restart bit, and yields one output word: the
// clamped drive (P plus I plus D) and a time fault flag that is set when the step time was
// zero, in which case the derivative term is zero. The integral only accumulates while the
// error magnitude is below the separation range; otherwise it is cleared. The block handles
// one word at a time and is not ready while it works. One shared multiplier forms every
// product from four 32x32 partial products; the derivative quotient comes from a restoring
// divider that runs beside the multiplier and produces min(64, DATA_WIDTH+FRAC_BITS+1) quotient
// bits. With a nonzero step time the divider sets the pace at the default widths; with a zero
// step time the divider is skipped. The block is ready for the next word in the cycle in which
// the result appears. The drive output is registered, so a new word is accepted while the
// previous result still waits to be taken; the result of the new word is held back until the
// output register is free. Configuration registers are written through a plain write port and
// take effect at once; they must only be written while the block is idle.
module pid_with_integral_separation #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidis_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_WIDTH-1:0]               cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]        error_sample_i,
  input  logic [DATA_WIDTH-2:0]               step_time_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [DATA_WIDTH-1:0]        drive_o,
  output logic                                time_fault_o
);

  localparam int AW = pidis_pkg::ACC_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PTERM  = 4'd1;
  localparam logic [3:0] ST_ITERM1 = 4'd2;
  localparam logic [3:0] ST_ITERM2 = 4'd3;
  localparam logic [3:0] ST_IACC   = 4'd4;
  localparam logic [3:0] ST_ICLAMP = 4'd5;
  localparam logic [3:0] ST_DWAIT  = 4'd6;
  localparam logic [3:0] ST_DTERM  = 4'd7;
  localparam logic [3:0] ST_SUM1   = 4'd8;
  localparam logic [3:0] ST_SUM2   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic signed [DATA_WIDTH-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DATA_WIDTH-1:0] out_upper_q, out_lower_q, int_upper_q, int_lower_q;
  logic        [DATA_WIDTH-2:0] sep_range_q;

  // Controller state and sequencer control.
  logic [3:0]                   state_q, state_d;
  logic                         first_q, first_d;
  logic signed [DATA_WIDTH-1:0] integ_q, integ_d;
  logic signed [DATA_WIDTH-1:0] prev_q, prev_d;
  logic                         mul_go_q, mul_go_d;
  logic                         div_go_q, div_go_d;
  logic                         deriv_rdy_q, deriv_rdy_d;
  logic                         out_valid_q, out_valid_d;

  // Per-word working registers.
  logic signed [DATA_WIDTH-1:0] err_q;
  logic        [DATA_WIDTH-2:0] dt_q;
  logic                         fault_q;
  logic                         sep_ok_q;
  pidis_pkg::s64_t              diff_q, deriv_q, p_q, tmp_q;
  logic signed [DATA_WIDTH-1:0] drive_q;
  logic                         time_fault_q;

  // Accept-side logic.
  logic                         in_fire, out_load;
  logic signed [DATA_WIDTH-1:0] prev_eff;
  logic signed [DATA_WIDTH:0]   diff_w;
  logic        [DATA_WIDTH-1:0] err_mag;
  logic                         sep_hit;

  // Shared multiplier and derivative divider.
  pidis_pkg::s64_t              mul_a, mul_b, mul_res, div_res;
  logic                         mul_done, div_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // A restart or the very first word takes the current error as the previous one.
  assign prev_eff = (restart_i || first_q) ? error_sample_i : prev_q;
  assign diff_w   = (DATA_WIDTH+1)'(error_sample_i) - (DATA_WIDTH+1)'(prev_eff);
  assign err_mag  = error_sample_i[DATA_WIDTH-1] ? -error_sample_i : error_sample_i;
  assign sep_hit  = err_mag < {1'b0, sep_range_q};

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_upper_q <= DMAX;
      out_lower_q <= DMIN;
      int_upper_q <= DMAX;
      int_lower_q <= DMIN;
      sep_range_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pidis_pkg::REG_GAIN_P:         gain_p_q    <= cfg_data_i;
        pidis_pkg::REG_GAIN_I:         gain_i_q    <= cfg_data_i;
        pidis_pkg::REG_GAIN_D:         gain_d_q    <= cfg_data_i;
        pidis_pkg::REG_OUTPUT_UPPER:   out_upper_q <= cfg_data_i;
        pidis_pkg::REG_OUTPUT_LOWER:   out_lower_q <= cfg_data_i;
        pidis_pkg::REG_INTEGRAL_UPPER: int_upper_q <= cfg_data_i;
        pidis_pkg::REG_INTEGRAL_LOWER: int_lower_q <= cfg_data_i;
        pidis_pkg::REG_SEP_RANGE:      sep_range_q <= cfg_data_i[DATA_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier follows the sequencer state.
  always_comb begin
    unique case (state_q)
      ST_ITERM1: begin
        mul_a = AW'(gain_i_q);
        mul_b = AW'(err_q);
      end
      ST_ITERM2: begin
        mul_a = tmp_q;
        mul_b = AW'({1'b0, dt_q});
      end
      ST_DTERM: begin
        mul_a = AW'(gain_d_q);
        mul_b = deriv_q;
      end
      default: begin
        mul_a = AW'(gain_p_q);
        mul_b = AW'(err_q);
      end
    endcase
  end

  pidis_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pidis_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .d_i     (diff_q),
    .t_i     (dt_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // Sequencer. The proportional and integral products run on the multiplier while the
  // divider works on the derivative; the derivative product waits for the quotient.
  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    integ_d     = integ_q;
    prev_d      = prev_q;
    mul_go_d    = 1'b0;
    div_go_d    = 1'b0;
    deriv_rdy_d = deriv_rdy_q | div_done;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          first_d     = 1'b0;
          prev_d      = error_sample_i;
          integ_d     = restart_i ? '0 : integ_q;
          mul_go_d    = 1'b1;
          div_go_d    = (step_time_i != '0);
          deriv_rdy_d = (step_time_i == '0);
          state_d     = ST_PTERM;
        end
      end
      ST_PTERM: begin
        if (mul_done) begin
          if (sep_ok_q) begin
            mul_go_d = 1'b1;
            state_d  = ST_ITERM1;
          end else begin
            // Error outside the separation range clears the integral.
            integ_d = '0;
            state_d = ST_DWAIT;
          end
        end
      end
      ST_ITERM1: begin
        if (mul_done) begin
          mul_go_d = 1'b1;
          state_d  = ST_ITERM2;
        end
      end
      ST_ITERM2: begin
        if (mul_done) state_d = ST_IACC;
      end
      ST_IACC: state_d = ST_ICLAMP;
      ST_ICLAMP: begin
        integ_d = DATA_WIDTH'(pidis_pkg::clamp(tmp_q, AW'(int_lower_q), AW'(int_upper_q)));
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (deriv_rdy_q) begin
          mul_go_d = 1'b1;
          state_d  = ST_DTERM;
        end
      end
      ST_DTERM: begin
        if (mul_done) state_d = ST_SUM1;
      end
      ST_SUM1: state_d = ST_SUM2;
      ST_SUM2: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      integ_q     <= '0;
      prev_q      <= '0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      deriv_rdy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      mul_go_q    <= mul_go_d;
      div_go_q    <= div_go_d;
      deriv_rdy_q <= deriv_rdy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q    <= error_sample_i;
      dt_q     <= step_time_i;
      fault_q  <= (step_time_i == '0);
      sep_ok_q <= sep_hit;
      diff_q   <= pidis_pkg::sat65((AW+1)'(diff_w));
      if (step_time_i == '0) deriv_q <= '0;
    end
    if (div_done) deriv_q <= div_res;
    if (mul_done) begin
      if (state_q == ST_PTERM) begin
        p_q <= mul_res;
      end else begin
        tmp_q <= mul_res;
      end
    end
    if (state_q == ST_IACC) tmp_q <= pidis_pkg::sat_add(AW'(integ_q), tmp_q);
    if (state_q == ST_SUM1) p_q <= pidis_pkg::sat_add(p_q, AW'(integ_q));
    if (state_q == ST_SUM2) p_q <= pidis_pkg::sat_add(p_q, tmp_q);
    if (out_load) begin
      drive_q      <= DATA_WIDTH'(pidis_pkg::clamp(p_q, AW'(out_lower_q), AW'(out_upper_q)));
      time_fault_q <= fault_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drive_o      = drive_q;
  assign time_fault_o = time_fault_q;

  // The block takes one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while the previous one is still in work");

  // The multiplier only reports a product in a state that waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_PTERM || state_q == ST_ITERM1 ||
                  state_q == ST_ITERM2 || state_q == ST_DTERM))
    else $error("multiplier result arrived outside a product state");

  // A waiting result is never overwritten by the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> state_q == ST_OUT)
    else $error("output register loaded while its word was not taken");

  // A zero step time gives a zero derivative for the derivative product.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DTERM && fault_q) |-> deriv_q == '0)
    else $error("nonzero derivative with a zero step time");

endmodule
